// ===== src/aes_pkg.sv =====
package aes_pkg;

   localparam int Rounds = 10;
   localparam int KeyDepth = 2 * (Rounds + 1);
   localparam int KeyAddrW = $clog2(KeyDepth);
   localparam int RoundW = $clog2(Rounds + 1);

   localparam logic [2:0] CSR_KEY_HIGH = 3'd0;
   localparam logic [2:0] CSR_KEY_LOW = 3'd1;
   localparam logic [2:0] CSR_IV_HIGH = 3'd2;
   localparam logic [2:0] CSR_IV_LOW = 3'd3;
   localparam logic [2:0] CSR_DECRYPT_MODE = 3'd4;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic        restart;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_KEY_FETCH, ST_KEY_STEP, ST_CIPH_FETCH, ST_CIPH_ROUND, ST_DONE
   } state_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a 128-bit word, AES order
   function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
      return s[127 - 8 * i -: 8];
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0] a0, a1, a2, a3, u, v;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = byte_at(s, 4 * c);
         a1 = byte_at(s, 4 * c + 1);
         a2 = byte_at(s, 4 * c + 2);
         a3 = byte_at(s, 4 * c + 3);
         // 14,11,13,9 matrix = mix of (a ^ 4a-terms) preconditioning
         u = xtime(xtime(a0 ^ a2));
         v = xtime(xtime(a1 ^ a3));
         a0 = a0 ^ u;
         a1 = a1 ^ v;
         a2 = a2 ^ u;
         a3 = a3 ^ v;
         u = a0 ^ a1 ^ a2 ^ a3;
         o[127 - 32 * c -: 8] = a0 ^ u ^ xtime(a0 ^ a1);
         o[119 - 32 * c -: 8] = a1 ^ u ^ xtime(a1 ^ a2);
         o[111 - 32 * c -: 8] = a2 ^ u ^ xtime(a2 ^ a3);
         o[103 - 32 * c -: 8] = a3 ^ u ^ xtime(a3 ^ a0);
      end
      return o;
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0] a0, a1, a2, a3, u;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = byte_at(s, 4 * c);
         a1 = byte_at(s, 4 * c + 1);
         a2 = byte_at(s, 4 * c + 2);
         a3 = byte_at(s, 4 * c + 3);
         u = a0 ^ a1 ^ a2 ^ a3;
         o[127 - 32 * c -: 8] = a0 ^ u ^ xtime(a0 ^ a1);
         o[119 - 32 * c -: 8] = a1 ^ u ^ xtime(a1 ^ a2);
         o[111 - 32 * c -: 8] = a2 ^ u ^ xtime(a2 ^ a3);
         o[103 - 32 * c -: 8] = a3 ^ u ^ xtime(a3 ^ a0);
      end
      return o;
   endfunction

   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] o;
      o = '0;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            o[127 - 8 * (r + 4 * c) -: 8] = sbox(byte_at(s, r + 4 * ((c + r) % 4)));
      return o;
   endfunction

   function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
      logic [127:0] o;
      o = '0;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            o[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = inv_sbox(byte_at(s, r + 4 * c));
      return o;
   endfunction

endpackage

// ===== src/aes_ram.sv =====
module aes_ram #(
   parameter int Width = 64,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== src/aes128_cbc_cipher_unit.sv =====
// a request passes through fetch, 10 rounds and done before its result is valid
// one block in flight at a time; set by cbc chaining through the single round unit
//   (accept, fetch, 10 rounds, done); a stalled result holds the next block in done
// a key write stalls requests through start, fetch and 11 key steps, one key per cycle
// reset (synchronous, active high): zero key expanded after reset, chaining value zero
module aes128_cbc_cipher_unit import aes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   // key stores: plain store holds round key r at entry 2r, inverse store its
   // inverse form at entry 2r+1; the address lsb picks the store
   logic                wr_en;
   logic [KeyAddrW-1:0] wr_addr, rd_addr;
   logic [127:0]        wr_data, rd_data;
   logic [127:0]        inv_rd;
   logic [127:0]        rd_mux;
   logic                sel_inv_ff;

   // inverse key is written in the cycle after the plain key
   logic              inv_pend_ff;
   logic [RoundW-1:0] inv_rnd_ff;
   logic [127:0]      inv_key_ff;
   logic [127:0]      inv_form;

   aes_ram #(.Width(128), .Depth(KeyDepth)) u_keys (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   state_type   state_ff, state_in;
   logic [127:0] key_ff, key_in;
   logic [127:0] iv_ff, iv_in;
   logic         dec_ff, dec_in;
   logic         expand_ff, expand_in;   // key changed, expansion pending
   logic [127:0] chain_ff, chain_in;
   logic [127:0] st_ff, st_in;            // cipher state
   logic [127:0] blk_ff, blk_in;          // input block kept for decrypt chaining
   logic [127:0] wk_ff, wk_in;            // key expansion working key
   logic [7:0]   rc_ff, rc_in;
   logic [RoundW-1:0] rnd_ff, rnd_in;
   rsp_type      out_ff, out_in;
   logic         out_valid_ff, out_valid_in;

   logic [127:0] next_wk;
   logic [31:0]  tw;

   assign req_stall = (state_ff != ST_IDLE) || expand_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // next round key from the working key
   always_comb begin
      tw = {sbox(wk_ff[23:16]) ^ rc_ff, sbox(wk_ff[15:8]), sbox(wk_ff[7:0]),
            sbox(wk_ff[31:24])};
      next_wk[127:96] = wk_ff[127:96] ^ tw;
      next_wk[95:64]  = wk_ff[95:64] ^ next_wk[127:96];
      next_wk[63:32]  = wk_ff[63:32] ^ next_wk[95:64];
      next_wk[31:0]   = wk_ff[31:0] ^ next_wk[63:32];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (expand_ff) state_in = ST_KEY_FETCH;
            else if (req_valid && !req_stall) state_in = ST_CIPH_FETCH;
         end
         ST_KEY_FETCH: state_in = ST_KEY_STEP;
         ST_KEY_STEP: if (rnd_ff == RoundW'(Rounds)) state_in = ST_IDLE;
         ST_CIPH_FETCH: state_in = ST_CIPH_ROUND;
         ST_CIPH_ROUND: if (rnd_ff == RoundW'(Rounds)) state_in = ST_DONE;
         // wait here while the previous result is still held
         ST_DONE: if (!(out_valid_ff && rsp_stall)) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [RoundW-1:0] kr;
      logic [127:0]      t;
      key_in = key_ff;
      iv_in = iv_ff;
      dec_in = dec_ff;
      expand_in = expand_ff;
      chain_in = chain_ff;
      st_in = st_ff;
      blk_in = blk_ff;
      wk_in = wk_ff;
      rc_in = rc_ff;
      rnd_in = rnd_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = wk_ff;
      rd_addr = '0;
      kr = '0;
      t = '0;

      if (csr_write) begin
         case (csr_index)
            CSR_KEY_HIGH: begin key_in[127:64] = csr_data; expand_in = 1'b1; end
            CSR_KEY_LOW: begin key_in[63:0] = csr_data; expand_in = 1'b1; end
            CSR_IV_HIGH: iv_in[127:64] = csr_data;
            CSR_IV_LOW: iv_in[63:0] = csr_data;
            CSR_DECRYPT_MODE: dec_in = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (expand_ff) begin
               expand_in = csr_write && (csr_index == CSR_KEY_HIGH
                                         || csr_index == CSR_KEY_LOW);
               wk_in = key_ff;
               rc_in = 8'h01;
               rnd_in = '0;
            end else if (req_valid && !req_stall) begin
               t = {req_data.block_high, req_data.block_low};
               blk_in = t;
               if (req_data.restart) chain_in = iv_ff;
               st_in = dec_ff ? t : t ^ (req_data.restart ? iv_ff : chain_ff);
               rnd_in = '0;
               rd_addr = dec_ff ? KeyAddrW'(2 * Rounds) : '0;
            end
         end
         ST_KEY_STEP: begin
            // write round key rnd, then advance
            wr_en = 1'b1;
            wr_addr = {rnd_ff, 1'b0};
            wr_data = wk_ff;
            rnd_in = rnd_ff + 1'b1;
            wk_in = next_wk;
            rc_in = xtime(rc_ff);
         end
         ST_CIPH_FETCH: begin
            st_in = st_ff ^ rd_mux;
            rnd_in = RoundW'(1);
            kr = dec_ff ? RoundW'(Rounds - 1) : RoundW'(1);
            rd_addr = {kr, dec_ff};
         end
         ST_CIPH_ROUND: begin
            if (dec_ff) begin
               t = inv_sub_shift(st_ff);
               if (rnd_ff != RoundW'(Rounds)) t = inv_mix(t);
               kr = RoundW'(Rounds - 1) - rnd_ff;
            end else begin
               t = sub_shift(st_ff);
               if (rnd_ff != RoundW'(Rounds)) t = mix(t);
               kr = rnd_ff + 1'b1;
            end
            st_in = t ^ rd_mux;
            rnd_in = rnd_ff + 1'b1;
            // no key is needed after the last round
            if (rnd_ff != RoundW'(Rounds)) rd_addr = {kr, dec_ff};
         end
         ST_DONE: begin
            if (!(out_valid_ff && rsp_stall)) begin
               t = dec_ff ? st_ff ^ chain_ff : st_ff;
               chain_in = dec_ff ? blk_ff : st_ff;
               out_in = rsp_type'(t);
               out_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         expand_ff <= 1'b1;
         out_valid_ff <= 1'b0;
         key_ff <= '0;
         iv_ff <= '0;
         dec_ff <= 1'b0;
         chain_ff <= '0;
         inv_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         expand_ff <= expand_in;
         out_valid_ff <= out_valid_in;
         key_ff <= key_in;
         iv_ff <= iv_in;
         dec_ff <= dec_in;
         chain_ff <= chain_in;
         inv_pend_ff <= (state_ff == ST_KEY_STEP);
      end
      st_ff <= st_in;
      blk_ff <= blk_in;
      wk_ff <= wk_in;
      rc_ff <= rc_in;
      rnd_ff <= rnd_in;
      out_ff <= out_in;
      inv_key_ff <= wk_ff;
      inv_rnd_ff <= rnd_ff;
      sel_inv_ff <= rd_addr[0];
   end

   // inverse-form store: written in the cycle after each plain key
   assign inv_form = (inv_rnd_ff == '0 || inv_rnd_ff == RoundW'(Rounds))
                     ? inv_key_ff : inv_mix(inv_key_ff);

   aes_ram #(.Width(128), .Depth(KeyDepth)) u_inv_keys (
      .clock(clock), .wr_en(inv_pend_ff), .wr_addr({inv_rnd_ff, 1'b1}),
      .wr_data(inv_form), .rd_addr(rd_addr), .rd_data(inv_rd)
   );

   // plain memory holds even entries; odd reads come from the inverse store
   assign rd_mux = sel_inv_ff ? inv_rd : rd_data;

endmodule

// ===== dv/aes128_cbc_cipher_unit_tb.sv =====
module aes128_cbc_cipher_unit_tb;
   import aes_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   aes128_cbc_cipher_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // request and result stores
   req_type request_queue[$];
   rsp_type expected_blocks[$];
   int      error_count = 0;

   // shadow of the block's registers and chaining state
   logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
   logic         decrypt_on;
   logic [127:0] chain_word;
   logic [127:0] enc_keys [0:10];
   logic [127:0] dec_keys [0:10];
   logic [7:0]   fwd_sub [0:255];
   logic [7:0]   rev_sub [0:255];

   // sender and receiver pacing
   int burst_left = 1;
   int gap_left = 0;
   bit request_taken = 0;
   int hold_cycles = 0;
   bit hold_request = 0;
   int stall_mode = 0;
   int mode_left = 0;

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- gf(2^8) helpers
   function automatic logic [7:0] dbl(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = dbl(a);
      end
      return acc;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] a, input int n);
      return (a << n) | (a >> (8 - n));
   endfunction

   // substitution tables from the field inverse and the affine map
   task automatic build_sub_tables();
      logic [7:0] inv, x, y;
      for (int i = 0; i < 256; i++) begin
         x = i[7:0];
         inv = 8'h00;
         for (int j = 1; j < 256; j++) begin
            y = j[7:0];
            if (x != 0 && gf_mul(x, y) == 8'h01) inv = y;
         end
         y = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
         fwd_sub[i] = y;
         rev_sub[y] = x;
      end
   endtask

   // ---------------------------------------------------------------- round functions
   function automatic logic [127:0] col_unmix(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         o[127 - 32 * c -: 8] = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11)
                                ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
         o[119 - 32 * c -: 8] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14)
                                ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
         o[111 - 32 * c -: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9)
                                ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
         o[103 - 32 * c -: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13)
                                ^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
      end
      return o;
   endfunction

   function automatic logic [127:0] col_mix(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         o[127 - 32 * c -: 8] = gf_mul(a0, 8'd2) ^ gf_mul(a1, 8'd3) ^ a2 ^ a3;
         o[119 - 32 * c -: 8] = a0 ^ gf_mul(a1, 8'd2) ^ gf_mul(a2, 8'd3) ^ a3;
         o[111 - 32 * c -: 8] = a0 ^ a1 ^ gf_mul(a2, 8'd2) ^ gf_mul(a3, 8'd3);
         o[103 - 32 * c -: 8] = gf_mul(a0, 8'd3) ^ a1 ^ a2 ^ gf_mul(a3, 8'd2);
      end
      return o;
   endfunction

   // byte substitution with row rotation, forward and inverse
   function automatic logic [127:0] subst_rows(input logic [127:0] s, input bit inverse);
      logic [127:0] o;
      int src;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            src = r + 4 * ((c + r) % 4);
            if (inverse)
               o[127 - 8 * src -: 8] = rev_sub[s[127 - 8 * (r + 4 * c) -: 8]];
            else
               o[127 - 8 * (r + 4 * c) -: 8] = fwd_sub[s[127 - 8 * src -: 8]];
         end
      return o;
   endfunction

   // standard aes-128 schedule; decrypt keys get the inverse column mix in the middle
   task automatic expand_cipher_key();
      logic [31:0] w [0:43];
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
      for (int i = 4; i < 44; i++) begin
         t = w[i - 1];
         if (i % 4 == 0) begin
            t = {fwd_sub[t[23:16]] ^ rc, fwd_sub[t[15:8]], fwd_sub[t[7:0]], fwd_sub[t[31:24]]};
            rc = dbl(rc);
         end
         w[i] = w[i - 4] ^ t;
      end
      for (int r = 0; r <= 10; r++) begin
         enc_keys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
         dec_keys[r] = (r > 0 && r < 10) ? col_unmix(enc_keys[r]) : enc_keys[r];
      end
   endtask

   // cbc step on one request, advancing the chaining state
   function automatic rsp_type cbc_predict(input req_type rq);
      logic [127:0] blk, s;
      rsp_type r;
      blk = {rq.block_high, rq.block_low};
      if (rq.restart) chain_word = {iv_hi, iv_lo};
      if (decrypt_on) begin
         s = blk ^ enc_keys[10];
         for (int k = 9; k >= 1; k--)
            s = col_unmix(subst_rows(s, 1)) ^ dec_keys[k];
         s = subst_rows(s, 1) ^ dec_keys[0];
         s ^= chain_word;
         chain_word = blk;
      end else begin
         s = blk ^ chain_word ^ enc_keys[0];
         for (int k = 1; k < 10; k++)
            s = col_mix(subst_rows(s, 0)) ^ enc_keys[k];
         s = subst_rows(s, 0) ^ enc_keys[10];
         chain_word = s;
      end
      {r.result_high, r.result_low} = s;
      return r;
   endfunction

   // ---------------------------------------------------------------- accept and check
   always @(posedge clock) begin
      rsp_type want;
      request_taken = 0;
      if (!reset && req_valid && !req_stall) begin
         expected_blocks.push_back(cbc_predict(req_data));
         request_taken = 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blocks.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_data.result_high !== want.result_high) begin
               $display("%0t: result_high expected %h actual %h", $time,
                        want.result_high, rsp_data.result_high);
               error_count++;
            end
            if (rsp_data.result_low !== want.result_low) begin
               $display("%0t: result_low expected %h actual %h", $time,
                        want.result_low, rsp_data.result_low);
               error_count++;
            end
         end
      end
   end

   // request driver: bursts of random length, random gaps in between
   always @(negedge clock) begin
      logic    nxt_valid;
      req_type nxt_data;
      nxt_valid = req_valid;
      nxt_data = req_data;
      if (reset) begin
         nxt_valid = 0;
      end else if (!req_valid || request_taken) begin
         nxt_valid = 0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (request_queue.size() > 0) begin
            nxt_data = request_queue.pop_front();
            nxt_valid = 1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               // about a third of bursts run back to back
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            end
         end
      end
      req_valid <= nxt_valid;
      req_data <= nxt_data;
   end

   // result stall pattern: free-running, light, heavy; plus one long hold-off
   always @(negedge clock) begin
      logic nxt_stall;
      if (hold_request) begin
         hold_request = 0;
         hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         nxt_stall = 1;
      end else begin
         if (mode_left <= 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         case (stall_mode)
            0: nxt_stall = 0;
            1: nxt_stall = ($urandom_range(0, 3) == 0);
            default: nxt_stall = ($urandom_range(0, 3) != 0);
         endcase
      end
      rsp_stall <= nxt_stall;
   end

   // ---------------------------------------------------------------- stimulus
   task automatic csr_put(input logic [2:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 0;
      case (idx)
         CSR_KEY_HIGH: begin key_hi = val; expand_cipher_key(); end
         CSR_KEY_LOW: begin key_lo = val; expand_cipher_key(); end
         CSR_IV_HIGH: iv_hi = val;
         CSR_IV_LOW: iv_lo = val;
         CSR_DECRYPT_MODE: decrypt_on = val[0];
         default: ;
      endcase
      // leave room for the key schedule to settle
      repeat (20) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (request_queue.size() != 0 || expected_blocks.size() != 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic add_request(input logic [63:0] hi, input logic [63:0] lo, input logic rs);
      req_type rq;
      rq.block_high = hi;
      rq.block_low = lo;
      rq.restart = rs;
      request_queue.push_back(rq);
   endtask

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 9))
         0: return 64'h0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int n;
      clock = 0;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      rsp_stall = 0;
      csr_write = 0;
      csr_index = CSR_KEY_HIGH;
      csr_data = '0;
      key_hi = 0;
      key_lo = 0;
      iv_hi = 0;
      iv_lo = 0;
      decrypt_on = 0;
      chain_word = '0;
      build_sub_tables();
      expand_cipher_key();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // zero key from reset, first blocks chain from zero without restart
      add_request(64'h0, 64'h0, 0);
      add_request('1, '1, 0);
      add_request(64'h0, 64'h0, 1);
      wait_drained();

      // well-known key and all-ones iv, then extremes of the data block
      csr_put(CSR_KEY_HIGH, 64'h0001020304050607);
      csr_put(CSR_KEY_LOW, 64'h08090a0b0c0d0e0f);
      csr_put(CSR_IV_HIGH, '1);
      csr_put(CSR_IV_LOW, '1);
      add_request(64'h0011223344556677, 64'h8899aabbccddeeff, 1);
      add_request('1, 64'h0, 0);
      add_request(64'h0, '1, 0);
      add_request(64'h8000000000000001, 64'h8000000000000001, 1);
      wait_drained();

      // mode change without restart keeps the chaining value
      csr_put(CSR_DECRYPT_MODE, 64'd1);
      add_request(64'h0123456789abcdef, 64'hfedcba9876543210, 0);
      add_request('1, '1, 0);
      add_request(64'h0, 64'h0, 1);
      wait_drained();

      // out-of-range indexes must leave every register alone
      csr_put(3'd5, '1);
      csr_put(3'd6, '1);
      csr_put(3'd7, 64'h1);
      add_request(64'h0011223344556677, 64'h8899aabbccddeeff, 0);
      add_request(64'h0, 64'h0, 1);
      // iv written mid-message takes effect only at the next restart
      wait_drained();
      csr_put(CSR_IV_HIGH, 64'h0);
      csr_put(CSR_IV_LOW, 64'h0);
      add_request(64'h55aa55aa55aa55aa, 64'haa55aa55aa55aa55, 0);
      add_request(64'h55aa55aa55aa55aa, 64'haa55aa55aa55aa55, 1);
      wait_drained();

      // random phases: fresh settings, then messages of random length
      for (int ph = 0; ph < 8; ph++) begin
         csr_put(CSR_KEY_HIGH, rand64());
         csr_put(CSR_KEY_LOW, rand64());
         csr_put(CSR_IV_HIGH, rand64());
         csr_put(CSR_IV_LOW, rand64());
         csr_put(CSR_DECRYPT_MODE, 64'(ph % 2));
         n = 0;
         while (n < 100) begin
            int msg_len;
            msg_len = $urandom_range(1, 12);
            for (int k = 0; k < msg_len; k++)
               add_request(rand64(), rand64(), (k == 0) ? 1'b1 : ($urandom_range(0, 19) == 0));
            n += msg_len;
         end
         // hold the result side off long enough for the input to back up
         if (ph == 2) hold_request = 1;
         wait_drained();
      end

      repeat (30) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // overall time limit
   initial begin
      #40000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
